FILE: design/cacc_pkg.sv
// Package for the chain atom clash check unit.
// Holds default parameters, item codes, class codes and inter-module structs.
// No dependencies.
package cacc_pkg;

  localparam int DEF_MAX_ATOMS  = 1024;
  localparam int DEF_COORD_BITS = 20;
  localparam int DEF_ATOM_TYPES = 3;

  localparam int POS_BITS   = 10;
  localparam int TYPE_BITS  = 2;
  localparam int INDEX_BITS = 5;
  localparam int THR_BITS   = 32;
  localparam int AXIS_BITS  = 16;
  localparam int SQ_BITS    = 2 * AXIS_BITS;
  localparam int SUM_BITS   = SQ_BITS + 2;

  localparam int CLASS_COUNT = 3;
  localparam int MIN_SEP     = 3;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ATOM = 1'b1;

  localparam logic [1:0] CLS_NEAR = 2'd0;
  localparam logic [1:0] CLS_MID  = 2'd1;
  localparam logic [1:0] CLS_FAR  = 2'd2;

  typedef struct packed {
    logic                  en;
    logic [INDEX_BITS-1:0] index;
    logic [THR_BITS-1:0]   value;
  } thr_load_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [1:0] cls;
  } pair_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } pair_res_t;

endpackage

FILE: design/chain_atom_clash_check_unit.sv
// Top level of the chain atom clash check unit: handshake, sequencer, atom store.
// Uses cacc_pkg, cacc_ram and cacc_pair_pipe.
//
// Input channel (in_valid / in_stall) carries one transaction per item. kind 0
// loads threshold_value into threshold entry table_index; kind 1 stores the atom
// (coord_x/y/z, atom_type) at position and checks it against every stored atom
// at least three positions lower. Output channel (out_valid / out_stall) returns
// one transaction per item with clash.
// A load, or an atom at position 0..2 (or beyond the store), needs no sweep and goes
// straight to the result. For an atom at position p >= 3 the atom store has one read
// port and is swept from entry 0 upward one entry per cycle, followed by a compare
// pipeline; the sweep ends early at the first clash. One item is processed at a time;
// in_stall is high while an item is in work.
// Reset clears the threshold table (via per-entry valid bits) and all control;
// the atom store is not cleared. A stalled result is held in the output register
// and the unit still accepts the next item, whose result waits until the output
// register is free.
module chain_atom_clash_check_unit #(
  parameter int MAX_ATOMS  = cacc_pkg::DEF_MAX_ATOMS,
  parameter int COORD_BITS = cacc_pkg::DEF_COORD_BITS,
  parameter int ATOM_TYPES = cacc_pkg::DEF_ATOM_TYPES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             kind,
  input  logic [cacc_pkg::POS_BITS-1:0]    position,
  input  logic signed [COORD_BITS-1:0]     coord_x,
  input  logic signed [COORD_BITS-1:0]     coord_y,
  input  logic signed [COORD_BITS-1:0]     coord_z,
  input  logic [cacc_pkg::TYPE_BITS-1:0]   atom_type,
  input  logic [cacc_pkg::INDEX_BITS-1:0]  table_index,
  input  logic [cacc_pkg::THR_BITS-1:0]    threshold_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             clash
);
  import cacc_pkg::*;

  localparam int AW     = $clog2(MAX_ATOMS);
  localparam int ATOM_W = 3 * COORD_BITS + TYPE_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic              in_acc, pos_ok, atom_we, out_free;
  logic [AW-1:0]     pos_reg, rd_idx, sep, wr_addr;
  logic              issue_on, res_hit, kill;
  logic [ATOM_W-1:0] new_atom, old_atom, in_word;
  thr_load_t         load;
  pair_ctl_t         ctl;
  pair_res_t         res;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign pos_ok   = int'(position) < MAX_ATOMS;
  assign atom_we  = in_acc && (kind == KIND_ATOM) && pos_ok;
  assign wr_addr  = AW'(position);
  assign in_word  = {atom_type, coord_z, coord_y, coord_x};
  assign out_free = !out_valid || !out_stall;

  assign load.en    = in_acc && (kind == KIND_LOAD);
  assign load.index = table_index;
  assign load.value = threshold_value;

  assign sep       = pos_reg - rd_idx;
  assign ctl.valid = (state == S_RUN) && issue_on;
  assign ctl.last  = (rd_idx == pos_reg - AW'(MIN_SEP));
  assign ctl.cls   = (sep == AW'(MIN_SEP))     ? CLS_NEAR :
                     (sep == AW'(MIN_SEP + 1)) ? CLS_MID  : CLS_FAR;
  assign kill      = res.valid && (res.hit || res.last);

  cacc_ram #(
    .WIDTH (ATOM_W),
    .DEPTH (MAX_ATOMS)
  ) u_atom_ram (
    .clk   (clk),
    .we    (atom_we),
    .waddr (wr_addr),
    .wdata (in_word),
    .raddr (rd_idx),
    .rdata (old_atom)
  );

  cacc_pair_pipe #(
    .COORD_BITS (COORD_BITS),
    .ATOM_TYPES (ATOM_TYPES)
  ) u_pair_pipe (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .ctl      (ctl),
    .kill     (kill),
    .new_atom (new_atom),
    .old_atom (old_atom),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      issue_on <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (atom_we && (int'(position) >= MIN_SEP)) begin
              issue_on <= 1'b1;
              state    <= S_RUN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_RUN: begin
          if (ctl.valid && ctl.last) begin
            issue_on <= 1'b0;
          end
          if (kill) begin
            issue_on <= 1'b0;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_reg  <= wr_addr;
      new_atom <= in_word;
      rd_idx   <= '0;
      res_hit  <= 1'b0;
    end else begin
      if (ctl.valid) begin
        rd_idx <= rd_idx + AW'(1);
      end
      if (kill) begin
        res_hit <= res.hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      clash <= res_hit;
    end
  end

  a_load_no_clash: assert property (@(posedge clk) disable iff (rst)
    in_acc && (kind == KIND_LOAD) |=> (state == S_DONE) && !res_hit)
    else $error("load transaction did not finish with clash clear");

  a_res_in_run: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == S_RUN))
    else $error("pair result outside of a sweep");

  a_read_below: assert property (@(posedge clk) disable iff (rst)
    ctl.valid |-> (int'(rd_idx) + MIN_SEP <= int'(pos_reg)))
    else $error("sweep read too close to the placed atom");

  a_kill_flush: assert property (@(posedge clk) disable iff (rst)
    kill |=> !res.valid)
    else $error("pair pipeline not flushed after sweep end");

endmodule

FILE: design/cacc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/cacc_pair_pipe.sv
// Pair check pipeline: axis differences, threshold table lookup, squares, compare.
// Holds the threshold table RAM and its valid bits. Uses cacc_pkg and cacc_ram.
module cacc_pair_pipe #(
  parameter int COORD_BITS = cacc_pkg::DEF_COORD_BITS,
  parameter int ATOM_TYPES = cacc_pkg::DEF_ATOM_TYPES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cacc_pkg::thr_load_t         load,
  input  cacc_pkg::pair_ctl_t         ctl,
  input  logic                        kill,
  input  logic [3*COORD_BITS+1:0]     new_atom,
  input  logic [3*COORD_BITS+1:0]     old_atom,
  output cacc_pkg::pair_res_t         res
);
  import cacc_pkg::*;

  localparam int TABLE_SIZE = ATOM_TYPES * ATOM_TYPES * CLASS_COUNT;
  localparam int TIDX_W     = $clog2(TABLE_SIZE);
  localparam int DIFF_W     = COORD_BITS + 1;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                  input logic signed [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = DIFF_W'(a) - DIFF_W'(b);
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  // stage 0: aligned with atom store read data
  logic        s0_vld, s0_last;
  logic [1:0]  s0_cls;

  // stage 1 combinational
  logic [DIFF_W-1:0]    mx, my, mz;
  logic                 far;
  logic [TYPE_BITS-1:0] tnew, told;
  logic                 tok;
  logic [TIDX_W-1:0]    thr_raddr, thr_waddr;
  logic                 thr_we;
  logic [THR_BITS-1:0]  thr_rdata;
  logic [TABLE_SIZE-1:0] thr_vld;

  // stage 1 registers
  logic                 s1_vld, s1_last, s1_far, s1_tok, s1_tvld;
  logic [AXIS_BITS-1:0] s1_mx, s1_my, s1_mz;

  // stage 2 registers
  logic                 s2_vld, s2_last, s2_far;
  logic [THR_BITS-1:0]  s2_thr;
  logic [SQ_BITS-1:0]   s2_sx, s2_sy, s2_sz;

  logic [THR_BITS-1:0]  thr_eff;
  logic [SUM_BITS-1:0]  dist_sq;

  always_comb begin
    mx   = abs_diff(new_atom[COORD_BITS-1:0], old_atom[COORD_BITS-1:0]);
    my   = abs_diff(new_atom[2*COORD_BITS-1:COORD_BITS], old_atom[2*COORD_BITS-1:COORD_BITS]);
    mz   = abs_diff(new_atom[3*COORD_BITS-1:2*COORD_BITS],
                    old_atom[3*COORD_BITS-1:2*COORD_BITS]);
    far  = ((mx >> AXIS_BITS) != '0) || ((my >> AXIS_BITS) != '0) ||
           ((mz >> AXIS_BITS) != '0);
    tnew = new_atom[3*COORD_BITS+1:3*COORD_BITS];
    told = old_atom[3*COORD_BITS+1:3*COORD_BITS];
    tok  = (int'(tnew) < ATOM_TYPES) && (int'(told) < ATOM_TYPES);
    thr_raddr = tok ? TIDX_W'((int'(tnew) * ATOM_TYPES + int'(told)) * CLASS_COUNT
                              + int'(s0_cls))
                    : '0;
  end

  assign thr_we    = load.en && (int'(load.index) < TABLE_SIZE);
  assign thr_waddr = TIDX_W'(load.index);

  cacc_ram #(
    .WIDTH (THR_BITS),
    .DEPTH (TABLE_SIZE)
  ) u_thr_ram (
    .clk   (clk),
    .we    (thr_we),
    .waddr (thr_waddr),
    .wdata (load.value),
    .raddr (thr_raddr),
    .rdata (thr_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_vld <= '0;
    end else if (thr_we) begin
      thr_vld[thr_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s0_vld <= ctl.valid && !kill;
      s1_vld <= s0_vld && !kill;
      s2_vld <= s1_vld && !kill;
    end
  end

  assign thr_eff = (s1_tok && s1_tvld) ? thr_rdata : '0;

  always_ff @(posedge clk) begin
    s0_last <= ctl.last;
    s0_cls  <= ctl.cls;
    s1_last <= s0_last;
    s1_far  <= far;
    s1_tok  <= tok;
    s1_tvld <= thr_vld[thr_raddr];
    s1_mx   <= AXIS_BITS'(mx);
    s1_my   <= AXIS_BITS'(my);
    s1_mz   <= AXIS_BITS'(mz);
    s2_last <= s1_last;
    s2_far  <= s1_far;
    s2_thr  <= thr_eff;
    s2_sx   <= SQ_BITS'(s1_mx) * SQ_BITS'(s1_mx);
    s2_sy   <= SQ_BITS'(s1_my) * SQ_BITS'(s1_my);
    s2_sz   <= SQ_BITS'(s1_mz) * SQ_BITS'(s1_mz);
  end

  assign dist_sq   = SUM_BITS'(s2_sx) + SUM_BITS'(s2_sy) + SUM_BITS'(s2_sz);
  assign res.valid = s2_vld;
  assign res.last  = s2_last;
  assign res.hit   = !s2_far && (dist_sq < SUM_BITS'(s2_thr));

endmodule

FILE: verif/testbench.sv
// Testbench for chain_atom_clash_check_unit: directed and random threshold loads and atom
// placements, with a clash predictor and in-order result checking. Depends on cacc_pkg and the DUT.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_ATOMS  = cacc_pkg::DEF_MAX_ATOMS;
  localparam int CW         = cacc_pkg::DEF_COORD_BITS;
  localparam int ATOM_TYPES = cacc_pkg::DEF_ATOM_TYPES;
  localparam int TABLE_SIZE = ATOM_TYPES * ATOM_TYPES * cacc_pkg::CLASS_COUNT;
  localparam int IDLE_PCT   = 24;
  localparam int HOLD_CYCLES = 1000;

  typedef struct packed {
    logic                              kind;
    logic [cacc_pkg::POS_BITS-1:0]     pos;
    logic [CW-1:0]                     x;
    logic [CW-1:0]                     y;
    logic [CW-1:0]                     z;
    logic [cacc_pkg::TYPE_BITS-1:0]    atype;
    logic [cacc_pkg::INDEX_BITS-1:0]   tidx;
    logic [cacc_pkg::THR_BITS-1:0]     tval;
  } atom_req_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [cacc_pkg::POS_BITS-1:0] position = '0;
  logic signed [CW-1:0] coord_x = '0;
  logic signed [CW-1:0] coord_y = '0;
  logic signed [CW-1:0] coord_z = '0;
  logic [cacc_pkg::TYPE_BITS-1:0] atom_type = '0;
  logic [cacc_pkg::INDEX_BITS-1:0] table_index = '0;
  logic [cacc_pkg::THR_BITS-1:0] threshold_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic clash;

  chain_atom_clash_check_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .position(position),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z),
    .atom_type(atom_type),
    .table_index(table_index),
    .threshold_value(threshold_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .clash(clash)
  );

  // predictor state
  logic [CW-1:0] atom_x [MAX_ATOMS];
  logic [CW-1:0] atom_y [MAX_ATOMS];
  logic [CW-1:0] atom_z [MAX_ATOMS];
  logic [cacc_pkg::TYPE_BITS-1:0] atom_kind [MAX_ATOMS];
  logic [cacc_pkg::THR_BITS-1:0] clash_thr [TABLE_SIZE];

  // stimulus generator state
  bit gen_placed [MAX_ATOMS];
  int gen_x [MAX_ATOMS];
  int gen_y [MAX_ATOMS];
  int gen_z [MAX_ATOMS];
  int gen_prefix = 0;

  atom_req_t pending[$];
  atom_req_t cur_req;
  logic clash_expected[$];
  logic want_clash;
  int sent_count = 0;
  int recv_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint axis_sq(input logic [CW-1:0] a, input logic [CW-1:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d < 0) d = -d;
    if (d >= (longint'(1) << cacc_pkg::AXIS_BITS)) return -1;
    return d * d;
  endfunction

  function automatic logic predict_clash(input atom_req_t r);
    int p;
    int sep;
    logic [1:0] cls;
    logic [cacc_pkg::THR_BITS-1:0] thr;
    longint sx, sy, sz;
    logic hit;
    hit = 1'b0;
    if (r.kind == cacc_pkg::KIND_LOAD) begin
      if (r.tidx < TABLE_SIZE) clash_thr[r.tidx] = r.tval;
      return 1'b0;
    end
    p = r.pos;
    atom_x[p] = r.x;
    atom_y[p] = r.y;
    atom_z[p] = r.z;
    atom_kind[p] = r.atype;
    for (int i = 0; i + cacc_pkg::MIN_SEP <= p && !hit; i++) begin
      sep = p - i;
      if (sep == cacc_pkg::MIN_SEP) cls = cacc_pkg::CLS_NEAR;
      else if (sep == cacc_pkg::MIN_SEP + 1) cls = cacc_pkg::CLS_MID;
      else cls = cacc_pkg::CLS_FAR;
      if (r.atype >= ATOM_TYPES || atom_kind[i] >= ATOM_TYPES) thr = '0;
      else thr = clash_thr[(r.atype * ATOM_TYPES + atom_kind[i]) * cacc_pkg::CLASS_COUNT + cls];
      sx = axis_sq(r.x, atom_x[i]);
      sy = axis_sq(r.y, atom_y[i]);
      sz = axis_sq(r.z, atom_z[i]);
      if (sx >= 0 && sy >= 0 && sz >= 0) hit = (sx + sy + sz) < longint'(thr);
    end
    return hit;
  endfunction

  task automatic push_load(input int idx, input logic [cacc_pkg::THR_BITS-1:0] val);
    atom_req_t r;
    r = '0;
    r.kind = cacc_pkg::KIND_LOAD;
    r.tidx = idx[cacc_pkg::INDEX_BITS-1:0];
    r.tval = val;
    pending.push_back(r);
  endtask

  task automatic push_atom(input int pos, input int x, input int y, input int z, input int t);
    atom_req_t r;
    r = '0;
    r.kind = cacc_pkg::KIND_ATOM;
    r.pos = pos[cacc_pkg::POS_BITS-1:0];
    r.x = x[CW-1:0];
    r.y = y[CW-1:0];
    r.z = z[CW-1:0];
    r.atype = t[cacc_pkg::TYPE_BITS-1:0];
    pending.push_back(r);
    gen_x[pos] = x;
    gen_y[pos] = y;
    gen_z[pos] = z;
    gen_placed[pos] = 1'b1;
    while (gen_prefix < MAX_ATOMS && gen_placed[gen_prefix]) gen_prefix++;
  endtask

  // next atom a bond-ish step away from its chain neighbor
  task automatic push_walk(input int pos);
    int bx, by, bz, t;
    bx = 0;
    by = 0;
    bz = 0;
    if (pos > 0 && gen_placed[pos-1]) begin
      bx = gen_x[pos-1];
      by = gen_y[pos-1];
      bz = gen_z[pos-1];
    end
    t = ($urandom_range(19) == 0) ? 3 : $urandom_range(ATOM_TYPES - 1);
    push_atom(pos, bx + int'($urandom_range(800)) - 400, by + int'($urandom_range(800)) - 400,
              bz + int'($urandom_range(800)) - 400, t);
  endtask

  function automatic int pick_pos(input int limit);
    int hi;
    hi = gen_prefix + 2;
    if (hi > limit) hi = limit;
    if (hi > MAX_ATOMS - 1) hi = MAX_ATOMS - 1;
    return $urandom_range(hi, 0);
  endfunction

  function automatic logic [cacc_pkg::THR_BITS-1:0] rand_thr();
    if ($urandom_range(1) == 0) return $urandom;
    return $urandom_range(12 << 16);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        clash_expected.push_back(predict_clash(cur_req));
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 &&
            ((sent_count >= 100 && sent_count < 200) || $urandom_range(99) >= IDLE_PCT)) begin
          cur_req = pending.pop_front();
          in_valid <= 1'b1;
          kind <= cur_req.kind;
          position <= cur_req.pos;
          coord_x <= cur_req.x;
          coord_y <= cur_req.y;
          coord_z <= cur_req.z;
          atom_type <= cur_req.atype;
          table_index <= cur_req.tidx;
          threshold_value <= cur_req.tval;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (clash_expected.size() == 0) begin
          $error("unexpected transaction: clash actual %b", clash);
          mismatch_count++;
        end else begin
          want_clash = clash_expected.pop_front();
          if (clash !== want_clash) begin
            $error("clash mismatch: expected %b, actual %b", want_clash, clash);
            mismatch_count++;
          end
        end
        recv_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && recv_count >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(recv_count >= 100 && recv_count < 200) &&
                     ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    int roll;
    int lo;
    // threshold table comes out of reset cleared
    for (int i = 0; i < TABLE_SIZE; i++) clash_thr[i] = '0;
    // directed: table extremes, ignored indexes, field extremes, far axes,
    // out-of-range type, threshold equality
    push_load(0, 32'hFFFF_FFFF);
    push_load(1, 32'hFFFF_FFFF);
    push_load(TABLE_SIZE - 1, 32'hFFFF_FFFF);
    push_load(31, 32'h0000_0001);
    push_load(TABLE_SIZE, 32'hFFFF_FFFF);
    push_atom(0, 524287, -524288, 0, 2);
    push_atom(1, 0, 0, 0, 0);
    push_atom(2, -524288, 524287, -1, 2);
    push_atom(3, 0, 0, 0, 0);
    push_atom(4, 0, 0, 0, 0);
    push_atom(5, 0, 0, 0, 3);
    push_atom(6, 65536, 0, 0, 0);
    push_atom(7, 65535, 0, 0, 0);
    push_load(14, 32'h0001_0000);
    push_atom(8, 0, 0, 0, 1);
    push_atom(9, 0, 0, 0, 1);
    push_atom(3, 0, 0, 0, 1);
    push_atom(10, 256, 0, 0, 1);
    push_atom(11, 255, 0, 0, 1);

    // random: realistic table, then a growing chain with revisits and noise
    for (int i = 0; i < TABLE_SIZE; i++) push_load(i, $urandom_range(12 << 16));
    while (gen_prefix < 440) begin
      roll = $urandom_range(99);
      if (roll < 85) push_walk(gen_prefix);
      else if (roll < 92) push_walk(pick_pos(48));
      else if (roll < 95) push_walk(pick_pos(MAX_ATOMS - 1));
      else if (roll < 97)
        push_atom(pick_pos(MAX_ATOMS - 1), $urandom, $urandom, $urandom,
                  $urandom_range(3));
      else push_load($urandom_range(31), rand_thr());
    end
    for (int i = 0; i < 40; i++) begin
      roll = $urandom_range(99);
      lo = gen_prefix - 40;
      if (roll < 50) push_walk($urandom_range(gen_prefix + 2, lo));
      else if (roll < 70) push_walk(pick_pos(32));
      else if (roll < 85)
        push_atom(pick_pos(MAX_ATOMS - 1), $urandom, $urandom, $urandom,
                  $urandom_range(3));
      else push_load($urandom_range(31), rand_thr());
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (pending.size() != 0 || in_valid || clash_expected.size() != 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
design/cacc_pkg.sv
design/cacc_ram.sv
design/cacc_pair_pipe.sv
design/chain_atom_clash_check_unit.sv
verif/testbench.sv
